@@ sv/ost_pkg.sv @@
package ost_pkg;

   localparam int SLOTS     = 256;
   localparam int IDX_W     = $clog2(SLOTS);
   localparam int CNT_W     = $clog2(SLOTS + 1);
   localparam int GEN_W     = 16;
   localparam int QTY_W     = 31;
   localparam int ID_W      = 32;
   localparam int EVICT_W   = 32;
   localparam logic [ID_W-1:0] ANONYMOUS = '0;

   localparam logic [2:0] CMD_ADMIT  = 3'd0;
   localparam logic [2:0] CMD_FILL   = 3'd1;
   localparam logic [2:0] CMD_CANCEL = 3'd2;
   localparam logic [2:0] CMD_REJECT = 3'd3;
   localparam logic [2:0] CMD_QUERY  = 3'd4;
   localparam logic [2:0] CMD_CLEAR  = 3'd5;

   localparam logic [3:0] RC_NONE      = 4'd0;
   localparam logic [3:0] RC_RESERVED  = 4'd1;
   localparam logic [3:0] RC_BAD_QTY   = 4'd2;
   localparam logic [3:0] RC_DUPLICATE = 4'd3;
   localparam logic [3:0] RC_FULL      = 4'd4;
   localparam logic [3:0] RC_UNKNOWN   = 4'd5;
   localparam logic [3:0] RC_FILLED    = 4'd6;
   localparam logic [3:0] RC_CANCELLED = 4'd7;
   localparam logic [3:0] RC_REJECTED  = 4'd8;
   localparam logic [3:0] RC_STALE     = 4'd9;

   localparam logic [2:0] ST_LIVE      = 3'd0;
   localparam logic [2:0] ST_PARTIAL   = 3'd1;
   localparam logic [2:0] ST_FILLED    = 3'd2;
   localparam logic [2:0] ST_CANCELLED = 3'd3;
   localparam logic [2:0] ST_REJECTED  = 3'd4;

   localparam int FLAG_REJ = 0;
   localparam int FLAG_CAN = 1;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [31:0]        order_id;
      logic signed [31:0] quantity;
      logic signed [31:0] price;
      logic [15:0]        symbol;
      logic [31:0]        account;
      logic [62:0]        entry_time;
      logic [7:0]         order_kind;
      logic [7:0]         handle_slot;
      logic [15:0]        handle_generation;
      logic [3:0]         why_code;
   } req_type;

   typedef struct packed {
      logic [3:0]  result_code;
      logic [7:0]  out_slot;
      logic [15:0] out_generation;
      logic        handle_ok;
      logic [30:0] remaining_qty;
      logic [30:0] traded_qty;
      logic [2:0]  order_status;
      logic [8:0]  live_count;
      logic [8:0]  peak_live;
      logic [31:0] eviction_count;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] price;
      logic [15:0]        symbol;
      logic [31:0]        account;
      logic [62:0]        entry_time;
      logic [7:0]         order_kind;
   } payload_type;

   typedef struct packed {
      logic [ID_W-1:0]  order_id;
      logic [GEN_W-1:0] gen;
      logic [QTY_W-1:0] remaining;
      logic [QTY_W-1:0] traded;
      logic [1:0]       flags;
      logic [3:0]       reason;
      payload_type      payload;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef enum logic [4:0] {
      ACT_NONE,
      ACT_LATCH,
      ACT_SCAN_INIT,
      ACT_SCAN,
      ACT_RD_HANDLE,
      ACT_RD_BUMP,
      ACT_RD_RING,
      ACT_RD_RSLOT,
      ACT_ADMIT,
      ACT_FILL,
      ACT_CANCEL,
      ACT_REJECT,
      ACT_QUERY,
      ACT_CODE,
      ACT_CLR_INIT,
      ACT_CLR_RD,
      ACT_CLR_WR,
      ACT_CLR_END,
      ACT_LOAD_OUT
   } act_type;

   typedef struct packed {
      act_type    act;
      logic [3:0] code;
   } ctl_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       id_zero;
      logic       qty_pos;
      logic       scan_hit;
      logic       scan_done;
      logic       bump_free;
      logic       ring_empty;
      logic       clr_done;
      logic       hdl_live;
      logic       fill_ok;
      logic       rej_ok;
      logic       out_free;
   } sts_type;

   function automatic logic [2:0] status_of(rec_type r);
      logic [2:0] st;
      if (r.flags[FLAG_REJ]) begin
         st = ST_REJECTED;
      end else if (r.flags[FLAG_CAN]) begin
         st = ST_CANCELLED;
      end else if (r.remaining == '0) begin
         st = ST_FILLED;
      end else if (r.traded != '0) begin
         st = ST_PARTIAL;
      end else begin
         st = ST_LIVE;
      end
      return st;
   endfunction

endpackage

@@ sv/ost_if.sv @@
interface ost_req_if;
   logic             valid;
   logic             ready;
   ost_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ost_rsp_if;
   logic             valid;
   logic             ready;
   ost_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ sv/ost_ram.sv @@
module ost_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ sv/ost_ctrl.sv @@
module ost_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ost_pkg::sts_type sts,
   output ost_pkg::ctl_type ctl
);
   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_SCAN, S_DUP, S_MISS, S_QREP, S_TAKE, S_RING,
      S_ADMIT, S_HDL, S_CLR_RD, S_CLR_WR, S_RESULT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctl.act  = ost_pkg::ACT_NONE;
      ctl.code = ost_pkg::RC_NONE;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.act  = ost_pkg::ACT_LATCH;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_RESULT;
            case (sts.cmd)
               ost_pkg::CMD_ADMIT: begin
                  if (sts.id_zero) begin
                     ctl.act  = ost_pkg::ACT_CODE;
                     ctl.code = ost_pkg::RC_RESERVED;
                  end else if (!sts.qty_pos) begin
                     ctl.act  = ost_pkg::ACT_CODE;
                     ctl.code = ost_pkg::RC_BAD_QTY;
                  end else begin
                     ctl.act  = ost_pkg::ACT_SCAN_INIT;
                     state_in = S_SCAN;
                  end
               end
               ost_pkg::CMD_FILL, ost_pkg::CMD_CANCEL, ost_pkg::CMD_REJECT: begin
                  ctl.act  = ost_pkg::ACT_RD_HANDLE;
                  state_in = S_HDL;
               end
               ost_pkg::CMD_QUERY: begin
                  if (sts.id_zero) begin
                     ctl.act  = ost_pkg::ACT_CODE;
                     ctl.code = ost_pkg::RC_UNKNOWN;
                  end else begin
                     ctl.act  = ost_pkg::ACT_SCAN_INIT;
                     state_in = S_SCAN;
                  end
               end
               ost_pkg::CMD_CLEAR: begin
                  ctl.act  = ost_pkg::ACT_CLR_INIT;
                  state_in = S_CLR_RD;
               end
               default: begin
                  ctl.act  = ost_pkg::ACT_CODE;
                  ctl.code = ost_pkg::RC_NONE;
               end
            endcase
         end
         S_SCAN: begin
            ctl.act = ost_pkg::ACT_SCAN;
            if (sts.scan_hit) begin
               state_in = (sts.cmd == ost_pkg::CMD_ADMIT) ? S_DUP : S_QREP;
            end else if (sts.scan_done) begin
               state_in = (sts.cmd == ost_pkg::CMD_ADMIT) ? S_TAKE : S_MISS;
            end
         end
         S_DUP: begin
            ctl.act  = ost_pkg::ACT_CODE;
            ctl.code = ost_pkg::RC_DUPLICATE;
            state_in = S_RESULT;
         end
         S_MISS: begin
            ctl.act  = ost_pkg::ACT_CODE;
            ctl.code = ost_pkg::RC_UNKNOWN;
            state_in = S_RESULT;
         end
         S_QREP: begin
            ctl.act  = ost_pkg::ACT_QUERY;
            state_in = S_RESULT;
         end
         S_TAKE: begin
            if (sts.bump_free) begin
               ctl.act  = ost_pkg::ACT_RD_BUMP;
               state_in = S_ADMIT;
            end else if (sts.ring_empty) begin
               ctl.act  = ost_pkg::ACT_CODE;
               ctl.code = ost_pkg::RC_FULL;
               state_in = S_RESULT;
            end else begin
               ctl.act  = ost_pkg::ACT_RD_RING;
               state_in = S_RING;
            end
         end
         S_RING: begin
            ctl.act  = ost_pkg::ACT_RD_RSLOT;
            state_in = S_ADMIT;
         end
         S_ADMIT: begin
            ctl.act  = ost_pkg::ACT_ADMIT;
            state_in = S_RESULT;
         end
         S_HDL: begin
            state_in = S_RESULT;
            ctl.act  = ost_pkg::ACT_CODE;
            ctl.code = ost_pkg::RC_STALE;
            case (sts.cmd)
               ost_pkg::CMD_FILL: begin
                  if (sts.fill_ok) begin
                     ctl.act = ost_pkg::ACT_FILL;
                  end
               end
               ost_pkg::CMD_CANCEL: begin
                  if (sts.hdl_live) begin
                     ctl.act = ost_pkg::ACT_CANCEL;
                  end
               end
               default: begin
                  if (sts.rej_ok) begin
                     ctl.act = ost_pkg::ACT_REJECT;
                  end
               end
            endcase
         end
         S_CLR_RD: begin
            if (sts.clr_done) begin
               ctl.act  = ost_pkg::ACT_CLR_END;
               state_in = S_RESULT;
            end else begin
               ctl.act  = ost_pkg::ACT_CLR_RD;
               state_in = S_CLR_WR;
            end
         end
         S_CLR_WR: begin
            ctl.act  = ost_pkg::ACT_CLR_WR;
            state_in = S_CLR_RD;
         end
         S_RESULT: begin
            if (sts.out_free) begin
               ctl.act  = ost_pkg::ACT_LOAD_OUT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

@@ sv/ost_dp.sv @@
module ost_dp (
   input  logic             clock,
   input  logic             reset,
   input  ost_pkg::req_type req_data,
   input  ost_pkg::ctl_type ctl,
   output ost_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ost_pkg::rsp_type rsp_data
);
   localparam int IDX_W = ost_pkg::IDX_W;
   localparam int CNT_W = ost_pkg::CNT_W;
   localparam int QTY_W_L = ost_pkg::QTY_W;

   ost_pkg::req_type req_ff, req_in;
   ost_pkg::rec_type hold_ff, hold_in;
   ost_pkg::rsp_type res_ff, res_in;
   ost_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             chk_v_ff, chk_v_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic             ev_ff, ev_in;
   logic [CNT_W-1:0] bump_ff, bump_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] live_ff, live_in;
   logic [CNT_W-1:0] peak_ff, peak_in;
   logic [ost_pkg::EVICT_W-1:0] evict_ff, evict_in;

   // Written-once marks: an unmarked slot reads as vacant with generation zero
   logic             vld_ff [ost_pkg::SLOTS];
   logic             vld_rd_ff;

   logic                     rec_we;
   logic [IDX_W-1:0]         rec_waddr, rec_raddr;
   ost_pkg::rec_type         rec_wdata, rec_rd, rec_q, nw;
   logic [ost_pkg::REC_W-1:0] rec_rdata;
   logic                     ring_we;
   logic [IDX_W-1:0]         ring_waddr, ring_rdata;
   logic                     retire, rep;
   ost_pkg::rec_type         rep_rec;
   logic [IDX_W-1:0]         rep_slot;
   logic [QTY_W_L-1:0]       qty_lo;
   logic                     qpos, hs_ok, hdl_live;

   ost_ram #(.WIDTH(ost_pkg::REC_W), .DEPTH(ost_pkg::SLOTS)) u_rec_ram (
      .clock(clock), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
      .raddr(rec_raddr), .rdata(rec_rdata)
   );

   ost_ram #(.WIDTH(IDX_W), .DEPTH(ost_pkg::SLOTS)) u_ring_ram (
      .clock(clock), .we(ring_we), .waddr(ring_waddr), .wdata(slot_ff),
      .raddr(head_ff), .rdata(ring_rdata)
   );

   assign rec_rd = ost_pkg::rec_type'(rec_rdata);

   always_comb begin
      rec_q = rec_rd;
      if (!vld_rd_ff) begin
         rec_q.order_id = ost_pkg::ANONYMOUS;
         rec_q.gen      = '0;
      end
   end

   assign qty_lo   = req_ff.quantity[QTY_W_L-1:0];
   assign qpos     = (req_ff.quantity != '0) && !req_ff.quantity[31];
   assign hs_ok    = 32'(req_ff.handle_slot) < 32'(ost_pkg::SLOTS);
   assign hdl_live = hs_ok && (rec_q.order_id != ost_pkg::ANONYMOUS)
                     && (rec_q.gen == req_ff.handle_generation)
                     && (ost_pkg::status_of(rec_q) < ost_pkg::ST_FILLED);

   always_comb begin
      sts.cmd        = req_ff.cmd;
      sts.id_zero    = (req_ff.order_id == ost_pkg::ANONYMOUS);
      sts.qty_pos    = qpos;
      sts.scan_hit   = chk_v_ff && (rec_q.order_id == req_ff.order_id);
      sts.scan_done  = (scan_ff == CNT_W'(ost_pkg::SLOTS)) && !sts.scan_hit;
      sts.bump_free  = bump_ff < CNT_W'(ost_pkg::SLOTS);
      sts.ring_empty = (count_ff == '0);
      sts.clr_done   = scan_ff >= bump_ff;
      sts.hdl_live   = hdl_live;
      sts.fill_ok    = hdl_live && qpos && (qty_lo <= rec_q.remaining);
      sts.rej_ok     = hdl_live && (rec_q.traded == '0);
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      req_in       = req_ff;
      hold_in      = hold_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      slot_in      = slot_ff;
      scan_in      = scan_ff;
      chk_v_in     = chk_v_ff;
      chk_idx_in   = chk_idx_ff;
      ev_in        = ev_ff;
      bump_in      = bump_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      live_in      = live_ff;
      peak_in      = peak_ff;
      evict_in     = evict_ff;
      rec_we       = 1'b0;
      rec_waddr    = slot_ff;
      rec_raddr    = '0;
      ring_we      = 1'b0;
      ring_waddr   = head_ff + count_ff[IDX_W-1:0];
      retire       = 1'b0;
      rep          = 1'b0;
      rep_rec      = rec_q;
      rep_slot     = slot_ff;
      nw           = rec_q;
      case (ctl.act)
         ost_pkg::ACT_LATCH: begin
            req_in = req_data;
         end
         ost_pkg::ACT_SCAN_INIT: begin
            scan_in  = '0;
            chk_v_in = 1'b0;
         end
         ost_pkg::ACT_SCAN: begin
            // one slot read per cycle, compared in the cycle after its read
            if (sts.scan_hit) begin
               hold_in  = rec_q;
               slot_in  = chk_idx_ff;
               chk_v_in = 1'b0;
            end else if (scan_ff < CNT_W'(ost_pkg::SLOTS)) begin
               rec_raddr  = scan_ff[IDX_W-1:0];
               chk_v_in   = 1'b1;
               chk_idx_in = scan_ff[IDX_W-1:0];
               scan_in    = scan_ff + 1'b1;
            end else begin
               chk_v_in = 1'b0;
            end
         end
         ost_pkg::ACT_RD_HANDLE: begin
            rec_raddr = req_ff.handle_slot[IDX_W-1:0];
            slot_in   = req_ff.handle_slot[IDX_W-1:0];
         end
         ost_pkg::ACT_RD_BUMP: begin
            rec_raddr = bump_ff[IDX_W-1:0];
            slot_in   = bump_ff[IDX_W-1:0];
            ev_in     = 1'b0;
            bump_in   = bump_ff + 1'b1;
         end
         ost_pkg::ACT_RD_RING: begin
            // ring read port follows head; data arrives next cycle
         end
         ost_pkg::ACT_RD_RSLOT: begin
            rec_raddr = ring_rdata;
            slot_in   = ring_rdata;
            ev_in     = 1'b1;
            head_in   = head_ff + 1'b1;
            count_in  = count_ff - 1'b1;
            if (evict_ff != '1) begin
               evict_in = evict_ff + 1'b1;
            end
         end
         ost_pkg::ACT_ADMIT: begin
            nw.order_id           = req_ff.order_id;
            nw.gen                = ev_ff ? rec_q.gen + 1'b1 : rec_q.gen;
            nw.remaining          = qty_lo;
            nw.traded             = '0;
            nw.flags              = '0;
            nw.reason             = '0;
            nw.payload.price      = req_ff.price;
            nw.payload.symbol     = req_ff.symbol;
            nw.payload.account    = req_ff.account;
            nw.payload.entry_time = req_ff.entry_time;
            nw.payload.order_kind = req_ff.order_kind;
            rec_we  = 1'b1;
            live_in = live_ff + 1'b1;
            if (live_in > peak_ff) begin
               peak_in = live_in;
            end
            res_in.result_code = ost_pkg::RC_NONE;
            rep     = 1'b1;
            rep_rec = nw;
         end
         ost_pkg::ACT_FILL: begin
            nw.remaining = rec_q.remaining - qty_lo;
            nw.traded    = rec_q.traded + qty_lo;
            rec_we = 1'b1;
            if (nw.remaining == '0) begin
               retire             = 1'b1;
               res_in.result_code = ost_pkg::RC_FILLED;
            end else begin
               res_in.result_code = ost_pkg::RC_NONE;
            end
            rep     = 1'b1;
            rep_rec = nw;
         end
         ost_pkg::ACT_CANCEL: begin
            nw.remaining           = '0;
            nw.flags[ost_pkg::FLAG_CAN] = 1'b1;
            nw.reason              = req_ff.why_code;
            rec_we  = 1'b1;
            retire  = 1'b1;
            res_in.result_code = ost_pkg::RC_CANCELLED;
            rep     = 1'b1;
            rep_rec = nw;
         end
         ost_pkg::ACT_REJECT: begin
            nw.remaining           = '0;
            nw.flags[ost_pkg::FLAG_REJ] = 1'b1;
            nw.reason              = req_ff.why_code;
            rec_we  = 1'b1;
            retire  = 1'b1;
            res_in.result_code = ost_pkg::RC_REJECTED;
            rep     = 1'b1;
            rep_rec = nw;
         end
         ost_pkg::ACT_QUERY: begin
            case (ost_pkg::status_of(hold_ff))
               ost_pkg::ST_FILLED:    res_in.result_code = ost_pkg::RC_FILLED;
               ost_pkg::ST_CANCELLED: res_in.result_code = ost_pkg::RC_CANCELLED;
               ost_pkg::ST_REJECTED:  res_in.result_code = ost_pkg::RC_REJECTED;
               default:               res_in.result_code = ost_pkg::RC_NONE;
            endcase
            rep     = 1'b1;
            rep_rec = hold_ff;
         end
         ost_pkg::ACT_CODE: begin
            res_in             = '0;
            res_in.result_code = ctl.code;
         end
         ost_pkg::ACT_CLR_INIT: begin
            scan_in = '0;
         end
         ost_pkg::ACT_CLR_RD: begin
            rec_raddr = scan_ff[IDX_W-1:0];
         end
         ost_pkg::ACT_CLR_WR: begin
            nw.order_id = ost_pkg::ANONYMOUS;
            nw.gen      = rec_q.gen + 1'b1;
            rec_we      = 1'b1;
            rec_waddr   = scan_ff[IDX_W-1:0];
            scan_in     = scan_ff + 1'b1;
         end
         ost_pkg::ACT_CLR_END: begin
            bump_in  = '0;
            head_in  = '0;
            count_in = '0;
            live_in  = '0;
            res_in   = '0;
         end
         ost_pkg::ACT_LOAD_OUT: begin
            rsp_in                = res_ff;
            rsp_in.live_count     = 9'(live_ff);
            rsp_in.peak_live      = 9'(peak_ff);
            rsp_in.eviction_count = 32'(evict_ff);
            rsp_valid_in          = 1'b1;
         end
         default: begin
         end
      endcase

      rec_wdata = nw;

      if (retire) begin
         if (count_ff < CNT_W'(ost_pkg::SLOTS)) begin
            ring_we  = 1'b1;
            count_in = count_ff + 1'b1;
         end
         if (live_ff != '0) begin
            live_in = live_ff - 1'b1;
         end
      end

      if (rep) begin
         res_in.out_slot       = 8'(rep_slot);
         res_in.out_generation = 16'(rep_rec.gen);
         res_in.handle_ok      = 1'b1;
         res_in.remaining_qty  = rep_rec.remaining;
         res_in.traded_qty     = rep_rec.traded;
         res_in.order_status   = ost_pkg::status_of(rep_rec);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         scan_ff      <= '0;
         chk_v_ff     <= 1'b0;
         ev_ff        <= 1'b0;
         bump_ff      <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         live_ff      <= '0;
         peak_ff      <= '0;
         evict_ff     <= '0;
         for (int i = 0; i < ost_pkg::SLOTS; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         scan_ff      <= scan_in;
         chk_v_ff     <= chk_v_in;
         ev_ff        <= ev_in;
         bump_ff      <= bump_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         live_ff      <= live_in;
         peak_ff      <= peak_in;
         evict_ff     <= evict_in;
         if (rec_we) begin
            vld_ff[rec_waddr] <= 1'b1;
         end
      end
      vld_rd_ff  <= vld_ff[rec_raddr];
      req_ff     <= req_in;
      hold_ff    <= hold_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
      slot_ff    <= slot_in;
      chk_idx_ff <= chk_idx_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

@@ sv/order_slot_table.sv @@
// Id search (admit, query) reads the slots in order and stops at the first match, else walks
// every slot; handle requests (fill, cancel, reject) read only the addressed slot; clear
// rewrites each slot handed out so far, bumping its generation.
// Throughput: one request in flight; the next is taken once the current result sits in the
// output register, and its own result then waits in S_RESULT until that register is free.
// Reset (synchronous): counters, ring pointers and per-slot written marks clear at once;
// no sweep through the record memory is needed.
module order_slot_table (
   input logic     clock,
   input logic     reset,
   ost_req_if.sink   req_ch,
   ost_rsp_if.source rsp_ch
);
   ost_pkg::ctl_type ctl;
   ost_pkg::sts_type sts;
   logic             req_ready;
   logic             rsp_valid;
   ost_pkg::rsp_type rsp_data;

   // sequencer: decodes the request and steps the search, handle and clear walks
   ost_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ready),
      .sts(sts), .ctl(ctl)
   );

   // record store, retired-slot ring, counters and output register
   ost_dp u_dp (
      .clock(clock), .reset(reset),
      .req_data(req_ch.data), .ctl(ctl), .sts(sts),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ch.ready), .rsp_data(rsp_data)
   );

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;
   assign rsp_ch.data  = rsp_data;
endmodule
